// File: rtl/core/mmfn_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mmfn_pkg;

    // field widths
    localparam int IDX_W     = 6;
    localparam int SAMPLE_W  = 16;
    localparam int VALUE_W   = 33;
    localparam int FRAC_BITS = 15;

    // divider: 32-bit magnitude quotient, one bit per step
    localparam int QUO_W = 32;
    localparam int CNT_W = 6;

    // op codes
    localparam logic OP_OBSERVE   = 1'b0;
    localparam logic OP_NORMALIZE = 1'b1;

    // extrema of a column never observed
    localparam logic signed [SAMPLE_W-1:0] MIN_RESET = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] MAX_RESET = 16'sh8000;

    typedef struct packed {
        logic capture;    // take the input item
        logic read;       // read the extrema entry
        logic eval;       // update extrema / set up the division
        logic div_start;  // launch the divider
        logic load;       // write the output register
    } mmfn_cmd_t;

    typedef struct packed {
        logic is_norm;
        logic zero_den;
        logic div_busy;
        logic div_done;
        logic out_free;
    } mmfn_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/mmfn_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface mmfn_in_if;
    logic                                         valid;
    logic                                         ready;
    logic                                         op;
    logic [mmfn_pkg::IDX_W-1:0]                   feature_index;
    logic signed [mmfn_pkg::SAMPLE_W-1:0]         sample_value;

    modport source (output valid, output op, output feature_index, output sample_value,
                    input ready);
    modport sink   (input valid, input op, input feature_index, input sample_value,
                    output ready);
endinterface

interface mmfn_out_if;
    logic                                         valid;
    logic                                         ready;
    logic signed [mmfn_pkg::VALUE_W-1:0]          normalized_value;
    logic                                         range_zero;

    modport source (output valid, output normalized_value, output range_zero,
                    input ready);
    modport sink   (input valid, input normalized_value, input range_zero,
                    output ready);
endinterface

`default_nettype wire

// File: rtl/core/mmfn_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module mmfn_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire mmfn_pkg::mmfn_stat_t stat,
    output mmfn_pkg::mmfn_cmd_t       cmd
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_READ = 5'b00010,
        ST_EVAL = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_LOAD = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_READ;
            end
            ST_READ:
                state_next = ST_EVAL;
            ST_EVAL:
            begin
                if (!stat.is_norm)
                    state_next = ST_IDLE;
                else if (stat.zero_den)
                    state_next = ST_LOAD;
                else
                    state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (stat.div_done)
                    state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (stat.out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_ready      = (state_reg == ST_IDLE);
    assign cmd.capture   = (state_reg == ST_IDLE) && in_valid;
    assign cmd.read      = (state_reg == ST_READ);
    assign cmd.eval      = (state_reg == ST_EVAL);
    assign cmd.div_start = (state_reg == ST_EVAL) && stat.is_norm && !stat.zero_den;
    assign cmd.load      = (state_reg == ST_LOAD) && stat.out_free;

endmodule

`default_nettype wire

// File: rtl/core/mmfn_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring radix-2 divider, unsigned, one quotient bit per cycle.
module mmfn_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [mmfn_pkg::QUO_W-1:0]    dividend,
    input  wire logic [mmfn_pkg::SAMPLE_W-1:0] divisor,
    output logic [mmfn_pkg::QUO_W-1:0]         quotient,
    output logic                               busy,
    output logic                               done
);

    localparam int DW = mmfn_pkg::SAMPLE_W;
    localparam int QW = mmfn_pkg::QUO_W;

    logic [DW-1:0]              rem_reg;
    logic [DW-1:0]              rem_next;
    logic [QW-1:0]              quo_reg;    // dividend bits shift out, quotient bits in
    logic [QW-1:0]              quo_next;
    logic [DW-1:0]              divisor_reg;
    logic [mmfn_pkg::CNT_W-1:0] cnt_reg;
    logic                       busy_reg;
    logic                       done_reg;

    logic [DW:0] shifted;
    logic [DW:0] trial;
    logic        fits;

    always_comb
    begin
        shifted  = {rem_reg, quo_reg[QW-1]};
        trial    = shifted - {1'b0, divisor_reg};
        fits     = (shifted >= {1'b0, divisor_reg});
        rem_next = fits ? trial[DW-1:0] : shifted[DW-1:0];
        quo_next = {quo_reg[QW-2:0], fits};
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg     <= '0;
            quo_reg     <= dividend;
            divisor_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= mmfn_pkg::CNT_W'(QW);
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == mmfn_pkg::CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    assign quotient = quo_reg;
    assign busy     = busy_reg;
    assign done     = done_reg;

endmodule

`default_nettype wire

// File: rtl/core/mmfn_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module mmfn_dp #(
    parameter int DEPTH = 64
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire mmfn_pkg::mmfn_cmd_t                  cmd,
    output mmfn_pkg::mmfn_stat_t                      stat,
    input  wire logic                                 op,
    input  wire logic [mmfn_pkg::IDX_W-1:0]           feature_index,
    input  wire logic signed [mmfn_pkg::SAMPLE_W-1:0] sample_value,
    output logic signed [mmfn_pkg::VALUE_W-1:0]       normalized_value,
    output logic                                      range_zero,
    output logic                                      res_valid,
    input  wire logic                                 res_ready
);

    localparam int SW = mmfn_pkg::SAMPLE_W;
    localparam int VW = mmfn_pkg::VALUE_W;
    localparam int QW = mmfn_pkg::QUO_W;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [mmfn_pkg::IDX_W:0] DEPTH_W = (mmfn_pkg::IDX_W + 1)'(DEPTH);

    // captured item
    logic                          op_reg;
    logic [mmfn_pkg::IDX_W-1:0]    idx_reg;
    logic signed [SW-1:0]          x_reg;
    logic                          hit_reg;
    logic [AW-1:0]                 addr;

    // extrema store: {min, max} per column, fill bits mark written entries
    logic [2*SW-1:0]               mem [DEPTH];
    logic [DEPTH-1:0]              fill_reg;
    logic [2*SW-1:0]               rd_data_reg;
    logic                          rd_fill_reg;

    logic signed [SW-1:0]          lo;
    logic signed [SW-1:0]          hi;
    logic signed [SW-1:0]          new_min;
    logic signed [SW-1:0]          new_max;
    logic signed [SW:0]            den;
    logic signed [SW:0]            sum;
    logic signed [SW+1:0]          diff;
    logic [SW+1:0]                 diff_mag;
    logic [SW:0]                   den_mag;
    logic [QW-1:0]                 dividend;
    logic                          wr_en;

    logic                          neg_reg;
    logic                          zero_reg;

    logic [QW-1:0]                 quotient;
    logic                          div_busy;
    logic                          div_done;

    logic [VW-1:0]                 quo_ext;
    logic signed [VW-1:0]          res_value;
    logic signed [VW-1:0]          res_value_reg;
    logic                          res_zero_reg;
    logic                          res_valid_reg;

    assign addr = idx_reg[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= op;
            idx_reg <= feature_index;
            x_reg   <= sample_value;
            hit_reg <= ({1'b0, feature_index} < DEPTH_W);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[addr] <= {new_min, new_max};
        if (cmd.read && hit_reg)
            rd_data_reg <= mem[addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg    <= '0;
            rd_fill_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
                fill_reg[addr] <= 1'b1;
            if (cmd.read)
                rd_fill_reg <= hit_reg && fill_reg[addr];
        end
    end

    always_comb
    begin
        lo       = rd_fill_reg ? rd_data_reg[2*SW-1:SW] : mmfn_pkg::MIN_RESET;
        hi       = rd_fill_reg ? rd_data_reg[SW-1:0]    : mmfn_pkg::MAX_RESET;
        new_min  = (x_reg < lo) ? x_reg : lo;
        new_max  = (x_reg > hi) ? x_reg : hi;
        den      = {hi[SW-1], hi} - {lo[SW-1], lo};
        sum      = {lo[SW-1], lo} + {hi[SW-1], hi};
        diff     = {x_reg[SW-1], x_reg, 1'b0} - {sum[SW], sum};
        diff_mag = diff[SW+1] ? -diff : diff;
        den_mag  = den[SW] ? -den : den;
        // |2x-(min+max)| < 2^17, scaled by 2^15
        dividend = {diff_mag[SW:0], {mmfn_pkg::FRAC_BITS{1'b0}}};
        wr_en    = cmd.eval && (op_reg == mmfn_pkg::OP_OBSERVE) && hit_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.eval)
        begin
            neg_reg  <= diff[SW+1] ^ den[SW];
            zero_reg <= (den == '0);
        end
    end

    mmfn_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dividend),
        .divisor  (den_mag[SW-1:0]),
        .quotient (quotient),
        .busy     (div_busy),
        .done     (div_done)
    );

    always_comb
    begin
        quo_ext = {1'b0, quotient};
        if (zero_reg)
            res_value = {{(VW-SW-mmfn_pkg::FRAC_BITS){x_reg[SW-1]}}, x_reg,
                         {mmfn_pkg::FRAC_BITS{1'b0}}};
        else if (neg_reg)
            res_value = -quo_ext;
        else
            res_value = quo_ext;
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            res_value_reg <= res_value;
            res_zero_reg  <= zero_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (cmd.load)
            res_valid_reg <= 1'b1;
        else if (res_ready)
            res_valid_reg <= 1'b0;
    end

    assign stat.is_norm  = (op_reg == mmfn_pkg::OP_NORMALIZE);
    assign stat.zero_den = (den == '0);
    assign stat.div_busy = div_busy;
    assign stat.div_done = div_done;
    assign stat.out_free = !res_valid_reg || res_ready;

    assign normalized_value = res_value_reg;
    assign range_zero       = res_zero_reg;
    assign res_valid        = res_valid_reg;

endmodule

`default_nettype wire

// File: rtl/core/min_max_feature_normalizer_unit.sv
// Channel  | Dir | Payload                                  | Notes
// ---------+-----+------------------------------------------+------------------------------
// sample   | in  | op, feature_index[5:0], sample_value[15:0] | op 0 observe, op 1 normalise
// result   | out | normalized_value[32:0] (Q.15), range_zero  | one per normalise item
//
// Observe items run read and set-up steps before the next ready; normalise items
// add the 32-step restoring divider (one quotient bit per cycle) plus done and load
// steps, or skip the divider when max equals min. One item is in flight at a time.
// Reset clears the fill bits of the extrema store, so every column reads as
// min 32767 / max -32768 at once; no clearing pass.
// The result sits in an output register: a stalled result channel holds the
// next normalise item at its load step, and the sample channel with it;
// observe items still pass while a result waits.
`timescale 1ns / 1ps
`default_nettype none

module min_max_feature_normalizer_unit #(
    parameter int NUM_FEATURES = 64
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    mmfn_in_if.sink    sample,
    mmfn_out_if.source result
);

    // feature_index reaches at most 2^6 columns
    localparam int IDX_SPAN = 1 << mmfn_pkg::IDX_W;
    localparam int DEPTH    = (NUM_FEATURES < IDX_SPAN) ? NUM_FEATURES : IDX_SPAN;

    mmfn_pkg::mmfn_cmd_t  cmd;
    mmfn_pkg::mmfn_stat_t stat;
    logic                 in_ready;

    mmfn_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sample.valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mmfn_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .op               (sample.op),
        .feature_index    (sample.feature_index),
        .sample_value     (sample.sample_value),
        .normalized_value (result.normalized_value),
        .range_zero       (result.range_zero),
        .res_valid        (result.valid),
        .res_ready        (result.ready)
    );

    assign sample.ready = in_ready;

    // no new transfer while a division is still running
    a_no_accept_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        (sample.valid && sample.ready) |-> !stat.div_busy)
        else $error("sample transfer during division");

    // output register is never overwritten while a result waits
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (!result.valid || result.ready))
        else $error("result overwritten before transfer");

    // pass-through results carry no fraction bits
    a_zero_frac: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.range_zero) |-> (result.normalized_value[14:0] == '0))
        else $error("range_zero result with fraction bits");

    // divider launch only for a normalise item with a non-zero range
    a_div_launch: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> (stat.is_norm && !stat.zero_den))
        else $error("divider started without a valid range");

endmodule

`default_nettype wire

// File: tb/min_max_feature_normalizer_unit_tb.sv
`timescale 1ns / 1ps

module min_max_feature_normalizer_unit_tb;

    localparam int NUM_FEATURES = 64;
    localparam int RANDOM_ITEMS = 900;

    // Column roles in the random part.
    // Flat columns only ever see one level, so max equals min once touched.
    // Blank columns are never observed and keep the reset extrema.
    localparam int FLAT_LO  = 48;
    localparam int FLAT_HI  = 55;
    localparam int BLANK_LO = 56;
    localparam int BLANK_HI = 61;

    // No transfer on either channel for this long means the block is stuck.
    // Worst legal stretch is a long sender gap, a divide and a long stall.
    localparam int STUCK_LIMIT = 2000;
    // Drain after the last result.
    localparam int DRAIN_CYCLES = 48;
    // Keep the log readable if the block is badly broken.
    localparam int REPORT_CAP = 50;

    typedef struct packed {
        logic                                 op;
        logic [mmfn_pkg::IDX_W-1:0]           feature_index;
        logic signed [mmfn_pkg::SAMPLE_W-1:0] sample_value;
    } sample_item_t;

    typedef struct packed {
        logic signed [mmfn_pkg::VALUE_W-1:0] normalized_value;
        logic                                range_zero;
    } norm_result_t;

    logic clk;
    logic rst_n;

    mmfn_in_if  sample_ch ();
    mmfn_out_if result_ch ();

    min_max_feature_normalizer_unit #(
        .NUM_FEATURES (NUM_FEATURES)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch)
    );

    // ------------------------------------------------------------------
    // Predictor state: our own copy of the per-column extrema.
    // ------------------------------------------------------------------
    logic signed [mmfn_pkg::SAMPLE_W-1:0] col_min [NUM_FEATURES];
    logic signed [mmfn_pkg::SAMPLE_W-1:0] col_max [NUM_FEATURES];

    sample_item_t sample_backlog [$];   // items still to be offered
    norm_result_t norm_expected  [$];   // results owed by the block

    int total_items;
    int items_taken;
    int fault_count;

    // Random column shapes
    int col_centre [NUM_FEATURES];
    int col_spread [NUM_FEATURES];
    int col_level  [NUM_FEATURES];

    // Append one item to the backlog.
    task automatic queue_sample(input sample_item_t it);
        sample_backlog = {sample_backlog, it};
    endtask

    // Fold one transferred item into the extrema, or work out the result it owes.
    // The divide is on 64-bit signed values: SV truncates toward zero, as wanted.
    task automatic apply_sample(input sample_item_t it);
        longint       lo;
        longint       hi;
        longint       x;
        longint       span;
        longint       num;
        longint       quo;
        norm_result_t res;
        lo = mmfn_pkg::MIN_RESET;
        hi = mmfn_pkg::MAX_RESET;
        x  = $signed(it.sample_value);
        if (it.feature_index < NUM_FEATURES)
        begin
            lo = col_min[it.feature_index];
            hi = col_max[it.feature_index];
        end
        if (it.op == mmfn_pkg::OP_OBSERVE)
        begin
            if (it.feature_index < NUM_FEATURES)
            begin
                if (x < lo)
                    col_min[it.feature_index] = it.sample_value;
                if (x > hi)
                    col_max[it.feature_index] = it.sample_value;
            end
            return;
        end
        span = hi - lo;
        if (span == 0)
        begin
            quo            = x <<< mmfn_pkg::FRAC_BITS;
            res.range_zero = 1'b1;
        end
        else
        begin
            num            = (2 * x - (lo + hi)) <<< mmfn_pkg::FRAC_BITS;
            quo            = num / span;
            res.range_zero = 1'b0;
        end
        // saturate to the 33-bit signed range; cannot trigger at 16-bit inputs
        if (quo > (longint'(1) <<< (mmfn_pkg::VALUE_W - 1)) - 1)
            quo = (longint'(1) <<< (mmfn_pkg::VALUE_W - 1)) - 1;
        if (quo < -(longint'(1) <<< (mmfn_pkg::VALUE_W - 1)))
            quo = -(longint'(1) <<< (mmfn_pkg::VALUE_W - 1));
        res.normalized_value = quo[mmfn_pkg::VALUE_W-1:0];
        norm_expected = {norm_expected, res};
    endtask

    function automatic sample_item_t make_item(input logic op, input int col, input int value);
        sample_item_t it;
        it.op            = op;
        it.feature_index = col[mmfn_pkg::IDX_W-1:0];
        it.sample_value  = value[mmfn_pkg::SAMPLE_W-1:0];
        return it;
    endfunction

    // Full-range sample, with the two extremes well represented.
    function automatic int any_sample();
        logic signed [mmfn_pkg::SAMPLE_W-1:0] s;
        logic [31:0]                          w;
        int                                   r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return -32768;
        if (r < 16)
            return 32767;
        w = $urandom;
        s = w[mmfn_pkg::SAMPLE_W-1:0];
        return int'(s);
    endfunction

    // Sample near a column's centre, clamped to the 16-bit range.
    function automatic int near_sample(input int col);
        int width;
        int v;
        width = 1 << col_spread[col];
        v     = col_centre[col] + int'($urandom_range(0, 2 * width)) - width;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v;
    endfunction

    // Mostly back to back, some short gaps, a rare long one.
    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 15);
        return $urandom_range(30, 90);
    endfunction

    // ------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------
    initial
    begin
        clk   = 1'b0;
        rst_n <= 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Driver: offers the backlog on the sample channel with random gaps.
    // The prediction is made at the transfer, so store order matches.
    // ------------------------------------------------------------------
    sample_item_t on_wire;
    int           send_gap;
    int           send_calm;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_ch.valid         <= 1'b0;
            sample_ch.op            <= mmfn_pkg::OP_OBSERVE;
            sample_ch.feature_index <= '0;
            sample_ch.sample_value  <= '0;
            send_gap                = draw_gap();
            send_calm               = 0;
        end
        else
        begin
            if (sample_ch.valid && sample_ch.ready)
            begin
                apply_sample(on_wire);
                items_taken++;
            end
            if (!sample_ch.valid || sample_ch.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    sample_ch.valid <= 1'b0;
                end
                else if (sample_backlog.size() > 0)
                begin
                    on_wire                 = sample_backlog.pop_front();
                    sample_ch.valid         <= 1'b1;
                    sample_ch.op            <= on_wire.op;
                    sample_ch.feature_index <= on_wire.feature_index;
                    sample_ch.sample_value  <= on_wire.sample_value;
                    // occasional run of back-to-back transfers
                    if (send_calm == 0 && $urandom_range(0, 63) == 0)
                        send_calm = $urandom_range(16, 48);
                    if (send_calm > 0)
                    begin
                        send_calm--;
                        send_gap = 0;
                    end
                    else
                        send_gap = draw_gap();
                end
                else
                    sample_ch.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: random back-pressure on the result channel, and the check.
    // ------------------------------------------------------------------
    int           stall_left;
    int           recv_calm;
    norm_result_t owed;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            stall_left      = 0;
            recv_calm       = 0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (norm_expected.size() == 0)
                begin
                    fault_count++;
                    if (fault_count <= REPORT_CAP)
                        $error("result with none owed: normalized_value %0d range_zero %0b",
                               result_ch.normalized_value, result_ch.range_zero);
                end
                else
                begin
                    owed = norm_expected.pop_front();
                    if (result_ch.normalized_value !== owed.normalized_value)
                    begin
                        fault_count++;
                        if (fault_count <= REPORT_CAP)
                            $error("normalized_value: expected %0d, got %0d",
                                   owed.normalized_value, result_ch.normalized_value);
                    end
                    if (result_ch.range_zero !== owed.range_zero)
                    begin
                        fault_count++;
                        if (fault_count <= REPORT_CAP)
                            $error("range_zero: expected %0b, got %0b",
                                   owed.range_zero, result_ch.range_zero);
                    end
                end
            end
            // stalls start at any cycle, so they land on every phase of the divide
            if (stall_left > 0)
            begin
                stall_left--;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                if (recv_calm == 0 && $urandom_range(0, 255) == 0)
                    recv_calm = $urandom_range(100, 400);
                if (recv_calm > 0)
                    recv_calm--;
                else if ($urandom_range(0, 5) == 0)
                    stall_left = draw_gap();
                if (stall_left > 0)
                begin
                    stall_left--;
                    result_ch.ready <= 1'b0;
                end
                else
                    result_ch.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: too long without any transfer ends the run.
    // ------------------------------------------------------------------
    int idle_cycles;

    always @(posedge clk)
    begin
        if (!rst_n || (sample_ch.valid && sample_ch.ready)
            || (result_ch.valid && result_ch.ready))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= STUCK_LIMIT)
            begin
                $display("min_max_feature_normalizer_unit_tb: errors");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin
        int   n;
        int   col;
        logic norm;
        int   value;

        for (n = 0; n < NUM_FEATURES; n++)
        begin
            col_min[n]    = mmfn_pkg::MIN_RESET;
            col_max[n]    = mmfn_pkg::MAX_RESET;
            col_centre[n] = any_sample();
            col_spread[n] = n % 14;
            col_level[n]  = any_sample();
        end
        items_taken = 0;
        fault_count = 0;
        idle_cycles = 0;

        // Directed part.
        // Columns never observed: reset extrema, span of -65535, no flag.
        queue_sample(make_item(mmfn_pkg::OP_NORMALIZE, 5, 0));
        queue_sample(make_item(mmfn_pkg::OP_NORMALIZE, 63, -32768));
        queue_sample(make_item(mmfn_pkg::OP_NORMALIZE, 0, 32767));
        // Single observation: max equals min, samples pass through flagged.
        queue_sample(make_item(mmfn_pkg::OP_OBSERVE, 1, 100));
        queue_sample(make_item(mmfn_pkg::OP_NORMALIZE, 1, 100));
        queue_sample(make_item(mmfn_pkg::OP_NORMALIZE, 1, -32768));
        queue_sample(make_item(mmfn_pkg::OP_NORMALIZE, 1, 32767));
        // Full 16-bit range: ends map to -1.0 and +1.0.
        queue_sample(make_item(mmfn_pkg::OP_OBSERVE, 2, -32768));
        queue_sample(make_item(mmfn_pkg::OP_OBSERVE, 2, 32767));
        queue_sample(make_item(mmfn_pkg::OP_NORMALIZE, 2, -32768));
        queue_sample(make_item(mmfn_pkg::OP_NORMALIZE, 2, 32767));
        queue_sample(make_item(mmfn_pkg::OP_NORMALIZE, 2, 0));
        queue_sample(make_item(mmfn_pkg::OP_NORMALIZE, 2, -1));
        // Span of one, samples far outside the range.
        queue_sample(make_item(mmfn_pkg::OP_OBSERVE, 3, 10));
        queue_sample(make_item(mmfn_pkg::OP_OBSERVE, 3, 11));
        queue_sample(make_item(mmfn_pkg::OP_NORMALIZE, 3, -32768));
        queue_sample(make_item(mmfn_pkg::OP_NORMALIZE, 3, 32767));
        queue_sample(make_item(mmfn_pkg::OP_NORMALIZE, 3, 11));
        // Largest positive quotient: span one at the bottom, sample at the top.
        queue_sample(make_item(mmfn_pkg::OP_OBSERVE, 4, -32768));
        queue_sample(make_item(mmfn_pkg::OP_OBSERVE, 4, -32767));
        queue_sample(make_item(mmfn_pkg::OP_NORMALIZE, 4, 32767));
        // Largest negative quotient, mirror image.
        queue_sample(make_item(mmfn_pkg::OP_OBSERVE, 62, 32767));
        queue_sample(make_item(mmfn_pkg::OP_OBSERVE, 62, 32766));
        queue_sample(make_item(mmfn_pkg::OP_NORMALIZE, 62, -32768));
        queue_sample(make_item(mmfn_pkg::OP_OBSERVE, 63, 0));

        // Random part. Most columns drift slowly around a centre, so spans
        // stay narrow for a while; some noise widens them.
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            col  = $urandom_range(0, NUM_FEATURES - 1);
            norm = ($urandom_range(0, 99) < 45);
            if (col >= BLANK_LO && col <= BLANK_HI)
            begin
                norm  = 1'b1;
                value = any_sample();
            end
            else if (col >= FLAT_LO && col <= FLAT_HI)
                value = (!norm || $urandom_range(0, 1) == 0) ? col_level[col] : any_sample();
            else if ($urandom_range(0, 99) < (norm ? 60 : 92))
                value = near_sample(col);
            else
                value = any_sample();
            queue_sample(make_item(norm ? mmfn_pkg::OP_NORMALIZE : mmfn_pkg::OP_OBSERVE,
                                   col, value));
        end
        total_items = sample_backlog.size();

        // Every item transferred, every result in, then a quiet tail.
        while (items_taken < total_items)
            @(posedge clk);
        while (norm_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fault_count == 0)
            $display("min_max_feature_normalizer_unit_tb: clean");
        else
            $display("min_max_feature_normalizer_unit_tb: errors");
        $finish;
    end

endmodule
